FILE: sv/tile_subpalette_repair_defines.svh
`ifndef TILE_SUBPALETTE_REPAIR_DEFINES_SVH
`define TILE_SUBPALETTE_REPAIR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TSR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tile_subpalette_repair: implication check failed");

// next-cycle implication, checked outside reset
`define TSR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tile_subpalette_repair: next-cycle check failed");

`endif

FILE: sv/tsr_pkg.sv
`timescale 1ns / 1ps
package tsr_pkg;

   localparam int PAL_ENTRIES = 256;
   localparam int TILE_PIXELS = 256;
   localparam int GROUP_W     = 4;
   localparam int IDX_W       = 8;
   localparam int CNT_W       = 9;
   localparam int COLOR_W     = 24;
   localparam int CSR_W       = 9;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CNT_W-1:0] MAX_CPP  = 9'd256;
   localparam logic [CNT_W-1:0] MAX_TOT  = 9'd256;
   localparam logic [CNT_W-1:0] FULL_CNT = 9'd256;

   typedef enum logic {
      CSR_CPP   = 1'b0,
      CSR_TOTAL = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_REPAIRED = 2'd1,
      ST_FAILED   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_PAL_WRITE  = 2'd0,
      CMD_PIXEL      = 2'd1,
      CMD_PIXEL_LAST = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [IDX_W-1:0]     index;
      logic [COLOR_W-1:0]   color;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] cpp;
      logic [CNT_W-1:0] tot;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CK_REQ,
      S_CK_FIRST,
      S_CK_BASE,
      S_CK_REQ2,
      S_CK_CMP,
      S_RP_INIT,
      S_RP_TREQ,
      S_RP_TDAT,
      S_RP_WANT,
      S_RP_EREQ,
      S_RP_ECMP,
      S_OUT_INIT,
      S_OUT_RD,
      S_OUT_CAP,
      S_OUT_SEND
   } state_type;

endpackage

FILE: sv/tsr_ram.sv
`timescale 1ns / 1ps
module tsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/tsr_front.sv
`timescale 1ns / 1ps
module tsr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [7:0]             req_entry_index,
   input  logic [23:0]            req_entry_color,
   input  logic [7:0]             req_pixel_index,
   input  logic                   req_last_pixel,
   output logic                   q_valid,
   output tsr_pkg::cmd_type       q_cmd,
   input  logic                   q_pop
);
   import tsr_pkg::*;

   cmd_type    slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    cmd;

   // classify the request
   always_comb begin
      cmd.color = req_entry_color;
      if (!req_func) begin
         cmd.kind  = CMD_PAL_WRITE;
         cmd.index = req_entry_index;
      end else begin
         cmd.kind  = req_last_pixel ? CMD_PIXEL_LAST : CMD_PIXEL;
         cmd.index = req_pixel_index;
      end
   end

   assign req_stall = (count_ff == 2'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end
endmodule

FILE: sv/tsr_back.sv
`timescale 1ns / 1ps
module tsr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tsr_pkg::cfg_type       cfg,
   input  logic                   q_valid,
   input  tsr_pkg::cmd_type       q_cmd,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_pixel_a,
   output logic [7:0]             rsp_out_pixel_b,
   output logic [7:0]             rsp_out_pixel_c,
   output logic [7:0]             rsp_out_pixel_d,
   output logic [2:0]             rsp_group_count,
   output logic [1:0]             rsp_tile_status,
   output logic                   rsp_last_group
);
   import tsr_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic [IDX_W-1:0]   first_ff, first_in;
   logic [CNT_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]   pb_ff, pb_in;
   logic [IDX_W-1:0]   c_ff, c_in;
   logic [COLOR_W-1:0] want_ff, want_in;
   status_type         status_ff, status_in;
   logic [IDX_W-1:0]   grp_ff [GROUP_W];
   logic [IDX_W-1:0]   grp_in [GROUP_W];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_pix_ff [GROUP_W];
   logic [IDX_W-1:0]   rsp_pix_in [GROUP_W];
   logic [2:0]         rsp_count_ff, rsp_count_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               pal_we, tile_we, remap_we;
   logic [IDX_W-1:0]   pal_rd_addr, tile_wr_addr, tile_rd_addr, remap_wr_addr;
   logic [COLOR_W-1:0] pal_rd;
   logic [IDX_W-1:0]   tile_rd, remap_rd, src_rd, remap_wr_data;

   logic [CNT_W:0]     base_end, pb_next, pb_end_next;
   logic [CNT_W-1:0]   entry;
   logic [CNT_W-1:0]   fill_next;
   logic               in_range, match, last_pix, slot_free, out_state;

   tsr_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_ENTRIES)) u_pal (
      .clock(clock), .wr_en(pal_we), .wr_addr(q_cmd.index), .wr_data(q_cmd.color),
      .rd_addr(pal_rd_addr), .rd_data(pal_rd));

   tsr_ram #(.WIDTH(IDX_W), .DEPTH(TILE_PIXELS)) u_tile (
      .clock(clock), .wr_en(tile_we), .wr_addr(tile_wr_addr), .wr_data(q_cmd.index),
      .rd_addr(tile_rd_addr), .rd_data(tile_rd));

   tsr_ram #(.WIDTH(IDX_W), .DEPTH(TILE_PIXELS)) u_remap (
      .clock(clock), .wr_en(remap_we), .wr_addr(remap_wr_addr), .wr_data(remap_wr_data),
      .rd_addr(tile_rd_addr), .rd_data(remap_rd));

   // shared datapath terms
   assign base_end    = {1'b0, base_ff} + {1'b0, cfg.cpp};
   assign pb_next     = {1'b0, pb_ff} + {1'b0, cfg.cpp};
   assign pb_end_next = pb_next + {1'b0, cfg.cpp};
   assign entry       = pb_ff + {1'b0, c_ff};
   assign in_range    = ({1'b0, tile_rd} >= base_ff) && ({2'b0, tile_rd} < base_end);
   assign match       = (pal_rd == want_ff);
   assign last_pix    = ({1'b0, i_ff} == n_ff - 9'd1);
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign fill_next   = (fill_ff == FULL_CNT) ? fill_ff : fill_ff + 9'd1;
   assign src_rd      = (status_ff == ST_REPAIRED) ? remap_rd : tile_rd;
   assign out_state   = (state_ff == S_OUT_RD) || (state_ff == S_OUT_CAP);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && q_cmd.kind == CMD_PIXEL_LAST) state_in = S_CK_REQ;
         end
         S_CK_REQ:   state_in = S_CK_FIRST;
         S_CK_FIRST: state_in = S_CK_BASE;
         S_CK_BASE: begin
            if ({2'b0, first_ff} < base_end) begin
               state_in = (n_ff == 9'd1) ? S_OUT_INIT : S_CK_REQ2;
            end
         end
         S_CK_REQ2: state_in = S_CK_CMP;
         S_CK_CMP: begin
            if (!in_range)     state_in = S_RP_INIT;
            else if (last_pix) state_in = S_OUT_INIT;
            else               state_in = S_CK_REQ2;
         end
         S_RP_INIT: state_in = (cfg.cpp > cfg.tot) ? S_OUT_INIT : S_RP_TREQ;
         S_RP_TREQ: state_in = S_RP_TDAT;
         S_RP_TDAT: state_in = S_RP_WANT;
         S_RP_WANT: state_in = S_RP_EREQ;
         S_RP_EREQ: state_in = S_RP_ECMP;
         S_RP_ECMP: begin
            if (match) begin
               state_in = last_pix ? S_OUT_INIT : S_RP_TREQ;
            end else if ({1'b0, c_ff} == cfg.cpp - 9'd1) begin
               state_in = (pb_end_next > {1'b0, cfg.tot}) ? S_OUT_INIT : S_RP_TREQ;
            end else begin
               state_in = S_RP_EREQ;
            end
         end
         S_OUT_INIT: state_in = S_OUT_RD;
         S_OUT_RD:   state_in = S_OUT_CAP;
         S_OUT_CAP: begin
            state_in = (j_ff + 9'd1 == n_ff || cnt_ff == 3'd3) ? S_OUT_SEND : S_OUT_RD;
         end
         S_OUT_SEND: begin
            if (slot_free) state_in = (j_ff == n_ff) ? S_IDLE : S_OUT_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      fill_in       = fill_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      cnt_in        = cnt_ff;
      first_in      = first_ff;
      base_in       = base_ff;
      pb_in         = pb_ff;
      c_in          = c_ff;
      want_in       = want_ff;
      status_in     = status_ff;
      grp_in        = grp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pix_in    = rsp_pix_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      pal_we        = 1'b0;
      tile_we       = 1'b0;
      remap_we      = 1'b0;
      tile_wr_addr  = fill_ff[IDX_W-1:0];
      remap_wr_addr = i_ff;
      remap_wr_data = entry[IDX_W-1:0];
      tile_rd_addr  = out_state ? j_ff[IDX_W-1:0] : i_ff;
      pal_rd_addr   = (state_ff == S_RP_TDAT) ? tile_rd : entry[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  CMD_PAL_WRITE: pal_we = 1'b1;
                  CMD_PIXEL: begin
                     tile_we = (fill_ff != FULL_CNT);
                     fill_in = fill_next;
                  end
                  CMD_PIXEL_LAST: begin
                     tile_we = (fill_ff != FULL_CNT);
                     n_in    = fill_next;
                     fill_in = '0;
                     i_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_CK_FIRST: begin
            first_in = tile_rd;
            base_in  = '0;
         end
         S_CK_BASE: begin
            if ({2'b0, first_ff} >= base_end) begin
               base_in = base_end[CNT_W-1:0];
            end else begin
               i_in      = 8'd1;
               status_in = ST_OK;
            end
         end
         S_CK_CMP: begin
            if (in_range && !last_pix) i_in = i_ff + 8'd1;
         end
         S_RP_INIT: begin
            pb_in     = '0;
            i_in      = '0;
            c_in      = '0;
            status_in = (cfg.cpp > cfg.tot) ? ST_FAILED : ST_OK;
         end
         S_RP_WANT: begin
            want_in = pal_rd;
            c_in    = '0;
         end
         S_RP_ECMP: begin
            if (match) begin
               remap_we = 1'b1;
               if (last_pix) status_in = ST_REPAIRED;
               else          i_in      = i_ff + 8'd1;
            end else if ({1'b0, c_ff} == cfg.cpp - 9'd1) begin
               if (pb_end_next > {1'b0, cfg.tot}) begin
                  status_in = ST_FAILED;
               end else begin
                  pb_in = pb_next[CNT_W-1:0];
                  i_in  = '0;
               end
            end else begin
               c_in = c_ff + 8'd1;
            end
         end
         S_OUT_INIT: begin
            j_in   = '0;
            cnt_in = '0;
            for (int k = 0; k < GROUP_W; k++) grp_in[k] = '0;
         end
         S_OUT_CAP: begin
            grp_in[cnt_ff[1:0]] = src_rd;
            j_in   = j_ff + 9'd1;
            cnt_in = cnt_ff + 3'd1;
         end
         S_OUT_SEND: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pix_in    = grp_ff;
               rsp_count_in  = cnt_ff;
               rsp_status_in = status_ff;
               rsp_last_in   = (j_ff == n_ff);
               cnt_in        = '0;
               for (int k = 0; k < GROUP_W; k++) grp_in[k] = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      cnt_ff        <= cnt_in;
      first_ff      <= first_in;
      base_ff       <= base_in;
      pb_ff         <= pb_in;
      c_ff          <= c_in;
      want_ff       <= want_in;
      status_ff     <= status_in;
      grp_ff        <= grp_in;
      rsp_pix_ff    <= rsp_pix_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_pixel_a = rsp_pix_ff[0];
   assign rsp_out_pixel_b = rsp_pix_ff[1];
   assign rsp_out_pixel_c = rsp_pix_ff[2];
   assign rsp_out_pixel_d = rsp_pix_ff[3];
   assign rsp_group_count = rsp_count_ff;
   assign rsp_tile_status = rsp_status_ff;
   assign rsp_last_group  = rsp_last_ff;
endmodule

FILE: sv/tile_subpalette_repair.sv
`timescale 1ns / 1ps
`include "tile_subpalette_repair_defines.svh"
// tile sub-palette repair
// request channel: req_valid/req_stall; req_func 0 writes palette entry
//    req_entry_index with req_entry_color, 1 adds req_pixel_index to the tile,
//    and req_last_pixel closes the tile
// response channel: rsp_valid/rsp_stall; one response per group of four pixels,
//    rsp_group_count valid pixels, rsp_tile_status ok/repaired/failed,
//    rsp_last_group on the tile's final group
// csr port: csr_write_enable, csr_index (0 colors per palette, 1 total colors)
//    and csr_write_data; write only while idle
// a two-entry request queue feeds a sequencer; palette writes and plain pixels
//    are taken by the sequencer while it is idle, and then stream at one per cycle
// closing a tile of n pixels: consistency check of the pixels plus the first
//    pixel's sub-palette search (one step per sub-palette), repair searching
//    each sub-palette tried for every pixel's color, one palette entry at a time
//    through the single read port of the palette memory; output reads each
//    pixel and sends one response per group
// reset empties the queue, the tile and the response register and restores
//    colors per palette 4 and total colors 32; memories are not cleared
// a stalled response holds; the sequencer waits on it and the queue fills,
//    then req_stall rises
module tile_subpalette_repair (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_entry_index,
   input  logic [23:0] req_entry_color,
   input  logic [7:0]  req_pixel_index,
   input  logic        req_last_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_pixel_a,
   output logic [7:0]  rsp_out_pixel_b,
   output logic [7:0]  rsp_out_pixel_c,
   output logic [7:0]  rsp_out_pixel_d,
   output logic [2:0]  rsp_group_count,
   output logic [1:0]  rsp_tile_status,
   output logic        rsp_last_group,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [8:0]  csr_write_data
);
   import tsr_pkg::*;

   logic [CSR_W-1:0] cpp_ff, tot_ff;
   cfg_type          cfg;
   logic             q_valid, q_pop;
   cmd_type          q_cmd;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cpp_ff <= 9'd4;
         tot_ff <= 9'd32;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CPP:   cpp_ff <= csr_write_data;
            CSR_TOTAL: tot_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // effective values: zero colors act as one, both clamp to the store size
   always_comb begin
      priority if (cpp_ff == '0)     cfg.cpp = 9'd1;
      else if (cpp_ff > MAX_CPP)     cfg.cpp = MAX_CPP;
      else                           cfg.cpp = cpp_ff;
      cfg.tot = (tot_ff > MAX_TOT) ? MAX_TOT : tot_ff;
   end

   // front: accept and classify requests into the queue
   tsr_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_entry_index(req_entry_index), .req_entry_color(req_entry_color),
      .req_pixel_index(req_pixel_index), .req_last_pixel(req_last_pixel),
      .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop));

   // back: palette and tile storage, check, repair and group output
   tsr_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_pixel_a(rsp_out_pixel_a), .rsp_out_pixel_b(rsp_out_pixel_b),
      .rsp_out_pixel_c(rsp_out_pixel_c), .rsp_out_pixel_d(rsp_out_pixel_d),
      .rsp_group_count(rsp_group_count), .rsp_tile_status(rsp_tile_status),
      .rsp_last_group(rsp_last_group));

   // a response group always carries one to four pixels
   `TSR_ASSERT_IMPL(a_count_range, rsp_valid, rsp_group_count != 3'd0 && rsp_group_count <= 3'd4)
   // only the final group of a tile may be short
   `TSR_ASSERT_IMPL(a_short_is_last, rsp_valid && rsp_group_count != 3'd4, rsp_last_group)
   // unused pixel slots read zero
   `TSR_ASSERT_IMPL(a_pad_zero, rsp_valid && rsp_group_count == 3'd1, rsp_out_pixel_b == 8'd0)
   // a group that is not last is followed by more of the same tile's status
   `TSR_ASSERT_NEXT(a_status_hold, rsp_valid && !rsp_stall && !rsp_last_group,
      $stable(rsp_tile_status) || !rsp_valid)
endmodule
